// ===== rtl/cwt_pkg.sv =====
// ----------------------------------------------------------------------------
// cwt_pkg: shared types and codes for the checkpoint window table
// Holds the entry layout, the control word to the cells, the request kinds
// and the result status codes.
// ----------------------------------------------------------------------------
package cwt_pkg;

  // Default table depth
  localparam int TABLE_ENTRIES_DEF = 1024;

  // Low depth bits that give the window length
  localparam logic [15:0] WINDOW_MASK = 16'hffff;

  // Request kinds
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_FIND   = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // Result status codes
  localparam logic [2:0] STATUS_INSERTED  = 3'd0;
  localparam logic [2:0] STATUS_REJECTED  = 3'd1;
  localparam logic [2:0] STATUS_FULL      = 3'd2;
  localparam logic [2:0] STATUS_FOUND     = 3'd3;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;
  localparam logic [2:0] STATUS_READ_OK   = 3'd5;

  // One stored checkpoint
  typedef struct packed {
    logic [30:0] block_height;
    logic [30:0] anchored_height;
    logic [31:0] depth;
    logic        root_nonzero;
  } entry_t;

  // Shift control shared by every cell of the chain
  typedef struct packed {
    logic push;  // move toward the tail, new word enters at the head
    logic rot;   // move toward the head, head word wraps to the tail
  } ctl_t;

endpackage

// ===== rtl/cwt_cell.sv =====
// ----------------------------------------------------------------------------
// cwt_cell: one storage cell of the checkpoint chain
// Holds one entry; takes the word from its older or newer neighbor.
// ----------------------------------------------------------------------------
module cwt_cell (
  input  logic            clk,
  input  cwt_pkg::ctl_t   ctl,
  input  cwt_pkg::entry_t from_prev,
  input  cwt_pkg::entry_t from_next,
  output cwt_pkg::entry_t entry
);

  cwt_pkg::entry_t entry_r;
  cwt_pkg::entry_t entry_nxt;

  // Select the neighbor word, hold otherwise
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.push) begin
      entry_nxt = from_prev;
    end else if (ctl.rot) begin
      entry_nxt = from_next;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== rtl/cwt_ctrl.sv =====
// ----------------------------------------------------------------------------
// cwt_ctrl: sequencer and head checker of the checkpoint window table
// Decides inserts, rotates the chain once around for find and read, checks
// the word at the head each cycle and keeps the summary registers.
// ----------------------------------------------------------------------------
module cwt_ctrl #(
  parameter int TABLE_ENTRIES = cwt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_kind,
  input  logic [30:0]           in_block_height,
  input  logic [30:0]           in_anchored_height,
  input  logic signed [31:0]    in_window_depth,
  input  logic                  in_root_nonzero,
  input  logic [30:0]           in_query_height,
  input  logic [9:0]            in_entry_index,
  input  cwt_pkg::entry_t       head,
  output cwt_pkg::ctl_t         ctl,
  output cwt_pkg::entry_t       new_entry,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic [9:0]            out_hit_index,
  output logic [30:0]           out_hit_block_height,
  output logic [30:0]           out_hit_anchored_height,
  output logic signed [31:0]    out_hit_depth,
  output logic                  out_hit_root_nonzero,
  output logic [10:0]           out_entries_used,
  output logic [30:0]           out_latest_anchored_height,
  output logic signed [31:0]    out_latest_depth,
  output logic [30:0]           out_prior_root_height
);

  localparam int UW = $clog2(TABLE_ENTRIES + 1);
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int EW = (UW > 10) ? UW : 10;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t          state_r, state_nxt;
  logic [IW-1:0]   cnt_r, cnt_nxt;
  logic [UW-1:0]   used_r, used_nxt;
  logic [30:0]     last_anc_r, last_anc_nxt;
  logic [31:0]     last_depth_r, last_depth_nxt;
  logic [30:0]     root_h_r, root_h_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [30:0]     qh_r, qh_nxt;
  logic [9:0]      ei_r, ei_nxt;
  logic            found_r, found_nxt;
  logic [UW-1:0]   hit_idx_r, hit_idx_nxt;
  cwt_pkg::entry_t hit_r, hit_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [2:0]      out_status_r, out_status_nxt;
  logic [UW-1:0]   out_idx_r, out_idx_nxt;
  cwt_pkg::entry_t out_hit_r, out_hit_nxt;
  logic [UW-1:0]   out_used_r, out_used_nxt;
  logic [30:0]     out_anc_r, out_anc_nxt;
  logic [31:0]     out_depth_r, out_depth_nxt;
  logic [30:0]     out_root_r, out_root_nxt;

  logic            accept;
  logic            in_range;
  logic [UW-1:0]   head_idx;
  logic [31:0]     win_top;
  logic            window_hit;
  logic            head_match;
  logic            last_step;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign new_entry.block_height    = in_block_height;
  assign new_entry.anchored_height = in_anchored_height;
  assign new_entry.depth           = in_window_depth;
  assign new_entry.root_nonzero    = in_root_nonzero;

  // Logical index of the word now at the head; valid while cnt < used
  assign in_range  = (UW'(cnt_r) < used_r);
  assign head_idx  = used_r - UW'(1) - UW'(cnt_r);
  assign last_step = (cnt_r == IW'(TABLE_ENTRIES - 1));

  // Window test: nonzero depth, query + length > anchored and query <= anchored
  assign win_top    = {1'b0, qh_r} + {16'b0, head.depth[15:0] & cwt_pkg::WINDOW_MASK};
  assign window_hit = (head.depth != 32'd0) && (win_top > {1'b0, head.anchored_height})
                      && (qh_r <= head.anchored_height);

  always_comb begin
    head_match = 1'b0;
    case (op_r)
      cwt_pkg::KIND_FIND: head_match = in_range && window_hit;
      cwt_pkg::KIND_READ: head_match = in_range && (EW'(head_idx) == EW'(ei_r));
      default:            head_match = 1'b0;
    endcase
  end

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    used_nxt       = used_r;
    last_anc_nxt   = last_anc_r;
    last_depth_nxt = last_depth_r;
    root_h_nxt     = root_h_r;
    op_nxt         = op_r;
    qh_nxt         = qh_r;
    ei_nxt         = ei_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_nxt        = hit_r;
    ctl.push       = 1'b0;
    ctl.rot        = (state_r == S_SCAN);
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_hit_nxt    = out_hit_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            cwt_pkg::KIND_INSERT: begin
              out_valid_nxt = 1'b1;
              out_idx_nxt   = '0;
              out_hit_nxt   = '0;
              if (in_anchored_height >= in_block_height) begin
                out_status_nxt = cwt_pkg::STATUS_REJECTED;
              end else if (used_r == UW'(TABLE_ENTRIES)) begin
                out_status_nxt = cwt_pkg::STATUS_FULL;
              end else begin
                out_status_nxt = cwt_pkg::STATUS_INSERTED;
                ctl.push       = 1'b1;
                used_nxt       = used_r + UW'(1);
                last_anc_nxt   = in_anchored_height;
                last_depth_nxt = in_window_depth;
                if (in_root_nonzero) begin
                  root_h_nxt = in_anchored_height;
                end
              end
            end
            cwt_pkg::KIND_FIND, cwt_pkg::KIND_READ: begin
              state_nxt = S_SCAN;
              cnt_nxt   = '0;
              found_nxt = 1'b0;
              op_nxt    = in_kind;
              qh_nxt    = in_query_height;
              ei_nxt    = in_entry_index;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = cwt_pkg::STATUS_NOT_FOUND;
              out_idx_nxt    = '0;
              out_hit_nxt    = '0;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Capture the newest match, advance one cell per cycle
        cnt_nxt = cnt_r + IW'(1);
        if (head_match && !found_r) begin
          found_nxt   = 1'b1;
          hit_idx_nxt = head_idx;
          hit_nxt     = head;
        end
        if (last_step) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (found_nxt) begin
            out_status_nxt = (op_r == cwt_pkg::KIND_READ) ? cwt_pkg::STATUS_READ_OK
                                                          : cwt_pkg::STATUS_FOUND;
            out_idx_nxt    = hit_idx_nxt;
            out_hit_nxt    = hit_nxt;
          end else begin
            out_status_nxt = cwt_pkg::STATUS_NOT_FOUND;
            out_idx_nxt    = '0;
            out_hit_nxt    = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_used_nxt  = used_nxt;
    out_anc_nxt   = last_anc_nxt;
    out_depth_nxt = last_depth_nxt;
    out_root_nxt  = root_h_nxt;
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      used_r       <= '0;
      last_anc_r   <= '0;
      last_depth_r <= '0;
      root_h_r     <= '0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      used_r       <= used_nxt;
      last_anc_r   <= last_anc_nxt;
      last_depth_r <= last_depth_nxt;
      root_h_r     <= root_h_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
      op_r         <= op_nxt;
      qh_r         <= qh_nxt;
      ei_r         <= ei_nxt;
      hit_idx_r    <= hit_idx_nxt;
      hit_r        <= hit_nxt;
      out_status_r <= out_status_nxt;
      out_idx_r    <= out_idx_nxt;
      out_hit_r    <= out_hit_nxt;
      out_used_r   <= out_used_nxt;
      out_anc_r    <= out_anc_nxt;
      out_depth_r  <= out_depth_nxt;
      out_root_r   <= out_root_nxt;
    end
  end

  assign out_valid                  = out_valid_r;
  assign out_status                 = out_status_r;
  assign out_hit_index              = 10'(out_idx_r);
  assign out_hit_block_height       = out_hit_r.block_height;
  assign out_hit_anchored_height    = out_hit_r.anchored_height;
  assign out_hit_depth              = $signed(out_hit_r.depth);
  assign out_hit_root_nonzero       = out_hit_r.root_nonzero;
  assign out_entries_used           = 11'(out_used_r);
  assign out_latest_anchored_height = out_anc_r;
  assign out_latest_depth           = $signed(out_depth_r);
  assign out_prior_root_height      = out_root_r;

endmodule

// ===== rtl/checkpoint_window_table_top.sv =====
// ----------------------------------------------------------------------------
// checkpoint_window_table_top: append-only checkpoint table
// Insert, unknown kind: result strobe in the cycle after start; busy stays low.
// Find, read: the chain of TABLE_ENTRIES cells rotates once past the head
// checker, one cell per cycle; busy stays high until the registered result
// strobe, and falls as it rises. The receiver cannot stall.
// Synchronous active-low reset empties the table and zeroes the summaries.
// ----------------------------------------------------------------------------
module checkpoint_window_table_top #(
  parameter int TABLE_ENTRIES = cwt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic [30:0]        in_block_height,
  input  logic [30:0]        in_anchored_height,
  input  logic signed [31:0] in_window_depth,
  input  logic               in_root_nonzero,
  input  logic [30:0]        in_query_height,
  input  logic [9:0]         in_entry_index,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [9:0]         out_hit_index,
  output logic [30:0]        out_hit_block_height,
  output logic [30:0]        out_hit_anchored_height,
  output logic signed [31:0] out_hit_depth,
  output logic               out_hit_root_nonzero,
  output logic [10:0]        out_entries_used,
  output logic [30:0]        out_latest_anchored_height,
  output logic signed [31:0] out_latest_depth,
  output logic [30:0]        out_prior_root_height
);

  cwt_pkg::ctl_t   ctl;
  cwt_pkg::entry_t new_entry;
  cwt_pkg::entry_t cell_q    [TABLE_ENTRIES];
  cwt_pkg::entry_t cell_prev [TABLE_ENTRIES];
  cwt_pkg::entry_t cell_next [TABLE_ENTRIES];

  // Build the ring: newest word at cell 0, the head wraps to the tail
  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_chain
    if (k == 0) begin : g_head
      assign cell_prev[k] = new_entry;
    end else begin : g_body
      assign cell_prev[k] = cell_q[k-1];
    end
    if (k == TABLE_ENTRIES - 1) begin : g_tail
      assign cell_next[k] = cell_q[0];
    end else begin : g_mid
      assign cell_next[k] = cell_q[k+1];
    end

    cwt_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .from_prev (cell_prev[k]),
      .from_next (cell_next[k]),
      .entry     (cell_q[k])
    );
  end

  cwt_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .start                      (start),
    .busy                       (busy),
    .in_kind                    (in_kind),
    .in_block_height            (in_block_height),
    .in_anchored_height         (in_anchored_height),
    .in_window_depth            (in_window_depth),
    .in_root_nonzero            (in_root_nonzero),
    .in_query_height            (in_query_height),
    .in_entry_index             (in_entry_index),
    .head                       (cell_q[0]),
    .ctl                        (ctl),
    .new_entry                  (new_entry),
    .out_valid                  (out_valid),
    .out_status                 (out_status),
    .out_hit_index              (out_hit_index),
    .out_hit_block_height       (out_hit_block_height),
    .out_hit_anchored_height    (out_hit_anchored_height),
    .out_hit_depth              (out_hit_depth),
    .out_hit_root_nonzero       (out_hit_root_nonzero),
    .out_entries_used           (out_entries_used),
    .out_latest_anchored_height (out_latest_anchored_height),
    .out_latest_depth           (out_latest_depth),
    .out_prior_root_height      (out_prior_root_height)
  );

endmodule
